>>> sv/ps2mt_pkg.sv
// Shared types and constants for the PS/2 mouse packet tracker.
`default_nettype none

package ps2mt_pkg;

    // Stream and field widths
    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 8;
    localparam int OUT_TDATA_W = 48;
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 18;
    localparam int BTN_W       = 3;
    localparam int DIVISOR_W   = 15;
    localparam int CFG_IDX_W   = 8;

    // Magnitude of a sign-extended 9-bit delta: 0 .. 256
    localparam int MAG_W = 9;

    // Status and header bit positions
    localparam int AUX_BIT    = 5;
    localparam int XSIGN_BIT  = 4;
    localparam int YSIGN_BIT  = 5;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 8'd1;

    // Register reset values
    localparam logic [DIVISOR_W-1:0] WIDTH_RESET  = 15'd640;
    localparam logic [DIVISOR_W-1:0] HEIGHT_RESET = 15'd480;

    // Position of a byte within a packet
    typedef enum logic [1:0] {
        BYTE_HDR = 2'd0,
        BYTE_X   = 2'd1,
        BYTE_Y   = 2'd2
    } byte_pos_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_ACC_X,
        ST_DIV_Y,
        ST_ACC_Y
    } state_t;

endpackage

`default_nettype wire

>>> sv/ps2_mouse_packet_tracker.sv
// PS/2 mouse packet tracker: packet framing, serial scaling divider, position update.
//
// Input stream (s_*): one request per byte read from the controller. s_tuser holds the
// status byte, s_tdata the data byte. Bytes without the aux-data status flag are taken
// and dropped. Mouse bytes form three-byte packets: header, X delta, Y delta.
// Output stream (m_*): one request per complete packet, with X and Y positions in
// signed Q1.FRAC_BITS, clamped to [-1, +1], plus button levels and changes.
// Config channel (cfg_*): register 0 screen width, 1 screen height (zero acts as one);
// always ready, write only while the block is idle.
// Timing: header, X and dropped bytes are taken while the sequencer is idle. The Y byte
// starts a restoring divider that produces one quotient bit per cycle, run once for X
// and once for Y, each pass followed by an accumulate step; the Y step writes the result
// to the output register and returns the sequencer to idle, ready for the next byte.
// The result sits in an output register; header and X bytes of the next packet are
// taken while it waits; once a Y byte is due, no byte is taken until the result is taken.
// Reset: positions, buttons and packet framing return to zero, the screen registers to
// 640 by 480, output not valid.
`default_nettype none

module ps2_mouse_packet_tracker #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // Input stream
    input  wire logic                                   s_tvalid,
    output      logic                                   s_tready,
    input  wire logic [ps2mt_pkg::IN_TDATA_W-1:0]       s_tdata,   // [7:0] data_byte
    input  wire logic [ps2mt_pkg::IN_TUSER_W-1:0]       s_tuser,   // [7:0] ctrl_status
    // Output stream
    output      logic                                   m_tvalid,
    input  wire logic                                   m_tready,
    // [17:0] x_position, [35:18] y_position, [38:36] button_levels,
    // [41:39] button_changes, [47:42] zero
    output      logic [ps2mt_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // Configuration write channel
    input  wire logic                                   cfg_valid,
    output      logic                                   cfg_ready,
    input  wire logic [ps2mt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [ps2mt_pkg::DIVISOR_W-1:0]        cfg_data
);

    localparam int MAG_W = ps2mt_pkg::MAG_W;
    localparam int DIV_W = ps2mt_pkg::DIVISOR_W;
    localparam int POS_W = ps2mt_pkg::POS_W;
    localparam int BTN_W = ps2mt_pkg::BTN_W;
    localparam int DVD_W = MAG_W + FRAC_BITS;
    localparam int ACC_W = FRAC_BITS + 2;
    localparam int SUM_W = DVD_W + 2;
    localparam int EXT_W = ACC_W + POS_W;
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam int PAD_W = ps2mt_pkg::OUT_TDATA_W - 2 * POS_W - 2 * BTN_W;

    localparam logic signed [SUM_W-1:0] ONE_S =
        {{(SUM_W - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [SUM_W-1:0] NEG_ONE_S = -ONE_S;

    // Control state
    ps2mt_pkg::state_t        state_reg, state_next;
    ps2mt_pkg::byte_pos_t     byte_idx_reg, byte_idx_next;
    logic [7:0]               header_reg, header_next;
    logic [7:0]               xbyte_reg, xbyte_next;
    logic [7:0]               ybyte_reg, ybyte_next;
    logic signed [ACC_W-1:0]  x_acc_reg, x_acc_next;
    logic signed [ACC_W-1:0]  y_acc_reg, y_acc_next;
    logic [BTN_W-1:0]         last_btn_reg, last_btn_next;
    logic                     m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     sub_reg, sub_next;
    logic [DIV_W-1:0]         width_reg, height_reg;

    // Datapath registers
    logic [DVD_W-1:0]                   dvd_reg, dvd_next;
    logic [DIV_W-1:0]                   rem_reg, rem_next;
    logic [DIV_W-1:0]                   div_reg, div_next;
    logic [ps2mt_pkg::OUT_TDATA_W-1:0]  tdata_reg, tdata_next;

    // Handshake helpers
    logic       in_acc;
    logic       aux;
    logic       x_neg, y_neg;
    logic [MAG_W-1:0] x_mag, y_mag;
    logic [DIV_W-1:0] width_eff, height_eff;

    // Divider step
    logic [DIV_W:0]   rem_shift;
    logic [DIV_W+1:0] diff;
    logic             borrow;

    // Accumulate step
    logic signed [ACC_W-1:0] acc_sel;
    logic signed [SUM_W-1:0] acc_wide, q_wide, sum, clamped;
    logic signed [ACC_W-1:0] acc_new;
    logic signed [EXT_W-1:0] x_ext, y_ext;
    logic [BTN_W-1:0]        levels;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ps2mt_pkg::ST_IDLE) &&
                       !(byte_idx_reg == ps2mt_pkg::BYTE_Y && m_valid_reg);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = tdata_reg;

    assign in_acc = s_tvalid && s_tready;
    assign aux    = s_tuser[ps2mt_pkg::AUX_BIT];

    // Sign and magnitude of the 9-bit deltas
    assign x_neg = header_reg[ps2mt_pkg::XSIGN_BIT];
    assign y_neg = header_reg[ps2mt_pkg::YSIGN_BIT];
    assign x_mag = x_neg ? MAG_W'(9'd256 - {1'b0, xbyte_reg}) : {1'b0, xbyte_reg};
    assign y_mag = y_neg ? MAG_W'(9'd256 - {1'b0, ybyte_reg}) : {1'b0, ybyte_reg};

    // Zero divisor acts as one
    assign width_eff  = (width_reg  == '0) ? DIV_W'(1) : width_reg;
    assign height_eff = (height_reg == '0) ? DIV_W'(1) : height_reg;

    // One restoring division step: one quotient bit per cycle
    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, div_reg};
    assign borrow    = diff[DIV_W+1];

    // Position update with clamp to [-1, +1]
    assign acc_sel  = (state_reg == ps2mt_pkg::ST_ACC_X) ? x_acc_reg : y_acc_reg;
    assign acc_wide = SUM_W'(acc_sel);
    assign q_wide   = signed'({2'b00, dvd_reg});
    assign sum      = sub_reg ? (acc_wide - q_wide) : (acc_wide + q_wide);

    always_comb
    begin
        if (sum > ONE_S)
        begin
            clamped = ONE_S;
        end
        else if (sum < NEG_ONE_S)
        begin
            clamped = NEG_ONE_S;
        end
        else
        begin
            clamped = sum;
        end
    end

    assign acc_new = clamped[ACC_W-1:0];
    assign x_ext   = EXT_W'(x_acc_reg);
    assign y_ext   = EXT_W'(acc_new);
    assign levels  = header_reg[BTN_W-1:0];

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next    = state_reg;
        byte_idx_next = byte_idx_reg;
        header_next   = header_reg;
        xbyte_next    = xbyte_reg;
        ybyte_next    = ybyte_reg;
        x_acc_next    = x_acc_reg;
        y_acc_next    = y_acc_reg;
        last_btn_next = last_btn_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        cnt_next      = cnt_reg;
        sub_next      = sub_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        div_next      = div_reg;
        tdata_next    = tdata_reg;

        unique case (state_reg)
            ps2mt_pkg::ST_IDLE:
            begin
                if (in_acc && aux)
                begin
                    unique case (byte_idx_reg)
                        ps2mt_pkg::BYTE_HDR:
                        begin
                            header_next   = s_tdata;
                            byte_idx_next = ps2mt_pkg::BYTE_X;
                        end
                        ps2mt_pkg::BYTE_X:
                        begin
                            xbyte_next    = s_tdata;
                            byte_idx_next = ps2mt_pkg::BYTE_Y;
                        end
                        ps2mt_pkg::BYTE_Y:
                        begin
                            ybyte_next    = s_tdata;
                            byte_idx_next = ps2mt_pkg::BYTE_HDR;
                            dvd_next      = {x_mag, {FRAC_BITS{1'b0}}};
                            rem_next      = '0;
                            div_next      = width_eff;
                            cnt_next      = CNT_W'(DVD_W);
                            sub_next      = x_neg;
                            state_next    = ps2mt_pkg::ST_DIV_X;
                        end
                        default:
                        begin
                            byte_idx_next = ps2mt_pkg::BYTE_HDR;
                        end
                    endcase
                end
            end
            ps2mt_pkg::ST_DIV_X, ps2mt_pkg::ST_DIV_Y:
            begin
                dvd_next = {dvd_reg[DVD_W-2:0], !borrow};
                rem_next = borrow ? rem_shift[DIV_W-1:0] : diff[DIV_W-1:0];
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = (state_reg == ps2mt_pkg::ST_DIV_X) ?
                                 ps2mt_pkg::ST_ACC_X : ps2mt_pkg::ST_ACC_Y;
                end
            end
            ps2mt_pkg::ST_ACC_X:
            begin
                x_acc_next = acc_new;
                dvd_next   = {y_mag, {FRAC_BITS{1'b0}}};
                rem_next   = '0;
                div_next   = height_eff;
                cnt_next   = CNT_W'(DVD_W);
                sub_next   = !y_neg;
                state_next = ps2mt_pkg::ST_DIV_Y;
            end
            ps2mt_pkg::ST_ACC_Y:
            begin
                y_acc_next    = acc_new;
                last_btn_next = levels;
                m_valid_next  = 1'b1;
                tdata_next    = {{PAD_W{1'b0}}, levels ^ last_btn_reg, levels,
                                 y_ext[POS_W-1:0], x_ext[POS_W-1:0]};
                state_next    = ps2mt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ps2mt_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ps2mt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control and tracking registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_idx_reg <= ps2mt_pkg::BYTE_HDR;
            header_reg   <= '0;
            xbyte_reg    <= '0;
            ybyte_reg    <= '0;
            x_acc_reg    <= '0;
            y_acc_reg    <= '0;
            last_btn_reg <= '0;
            m_valid_reg  <= 1'b0;
            cnt_reg      <= '0;
            sub_reg      <= 1'b0;
        end
        else
        begin
            byte_idx_reg <= byte_idx_next;
            header_reg   <= header_next;
            xbyte_reg    <= xbyte_next;
            ybyte_reg    <= ybyte_next;
            x_acc_reg    <= x_acc_next;
            y_acc_reg    <= y_acc_next;
            last_btn_reg <= last_btn_next;
            m_valid_reg  <= m_valid_next;
            cnt_reg      <= cnt_next;
            sub_reg      <= sub_next;
        end
    end

    // Screen size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ps2mt_pkg::WIDTH_RESET;
            height_reg <= ps2mt_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ps2mt_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                ps2mt_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Divider and output payload
    always_ff @(posedge clk)
    begin
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        tdata_reg <= tdata_next;
    end

`ifndef SYNTHESIS
    // No input taken while the divider runs
    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ps2mt_pkg::ST_IDLE) |-> !s_tready)
        else $error("input taken while busy");

    // Output register is free when a result is written
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ps2mt_pkg::ST_ACC_Y) |-> !m_valid_reg)
        else $error("result overwrites a pending result");

    // A Y byte starts the X division
    a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && aux && byte_idx_reg == ps2mt_pkg::BYTE_Y) |=>
        (state_reg == ps2mt_pkg::ST_DIV_X))
        else $error("division not started");

    // Positions stay within [-1, +1]
    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        (SUM_W'(x_acc_reg) <= ONE_S) && (SUM_W'(x_acc_reg) >= NEG_ONE_S))
        else $error("x position out of range");

    a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        (SUM_W'(y_acc_reg) <= ONE_S) && (SUM_W'(y_acc_reg) >= NEG_ONE_S))
        else $error("y position out of range");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_ps2_mouse_packet_tracker.sv
// Self-checking testbench for the PS/2 mouse packet tracker: stream driver, monitor, tracker model.
module tb_ps2_mouse_packet_tracker;

    // Widths taken from the shared package
    localparam int BYTE_W      = ps2mt_pkg::BYTE_W;
    localparam int POS_W       = ps2mt_pkg::POS_W;
    localparam int BTN_W       = ps2mt_pkg::BTN_W;
    localparam int OUT_TDATA_W = ps2mt_pkg::OUT_TDATA_W;
    localparam int IN_TDATA_W  = ps2mt_pkg::IN_TDATA_W;
    localparam int IN_TUSER_W  = ps2mt_pkg::IN_TUSER_W;
    localparam int CFG_IDX_W   = ps2mt_pkg::CFG_IDX_W;
    localparam int DIVISOR_W   = ps2mt_pkg::DIVISOR_W;

    localparam int FRAC = 16;
    localparam logic [BYTE_W-1:0] AUX_FLAG = 8'h20;
    localparam int SETTLE_CYCLES = 2 * (FRAC + 9) + 12;
    localparam int MAX_REPORTED = 10;

    // One byte read from the controller
    typedef struct {
        logic [BYTE_W-1:0] status;
        logic [BYTE_W-1:0] data;
    } ctrl_read_t;

    // One packet report on the output stream
    typedef struct {
        logic [POS_W-1:0] x_pos;
        logic [POS_W-1:0] y_pos;
        logic [BTN_W-1:0] levels;
        logic [BTN_W-1:0] changes;
        logic [OUT_TDATA_W-4*BTN_W-2*POS_W+BTN_W*2-1:0] pad;
    } mouse_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [DIVISOR_W-1:0]   cfg_data = '0;

    // Stimulus bookkeeping
    ctrl_read_t pending_reads[$];
    ctrl_read_t next_read;
    mouse_report_t expected_reports[$];
    int reads_queued = 0;
    int reads_taken = 0;
    int burst_left = 1;
    int gap_left = 0;
    int fail_count = 0;

    // Receiver pattern
    int rx_cycle = 0;
    int rx_mode = 0;
    int hold_left = 0;

    // Tracker model state and configuration
    logic [DIVISOR_W-1:0]   model_width;
    logic [DIVISOR_W-1:0]   model_height;
    ps2mt_pkg::byte_pos_t   model_pos;
    logic [BYTE_W-1:0]      model_header;
    logic [BYTE_W-1:0]      model_dx;
    longint                 model_x;
    longint                 model_y;
    logic [BTN_W-1:0]       model_buttons;

    ps2_mouse_packet_tracker #(
        .FRAC_BITS(FRAC)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),      // [7:0] data_byte
        .s_tuser(s_tuser),      // [7:0] ctrl_status
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),      // [17:0] x, [35:18] y, [38:36] levels, [41:39] changes
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Signed step: |delta| scaled by 2^FRAC, divided with truncation, sign restored
    function automatic longint scaled_move(logic [BYTE_W-1:0] raw, logic neg,
                                           logic [DIVISOR_W-1:0] divisor);
        longint d;
        longint mag;
        longint dv;
        longint q;
        d = longint'(raw);
        if (neg)
            d = d - 256;
        mag = (d < 0) ? -d : d;
        if (divisor == '0)
            dv = 1;
        else
            dv = longint'(divisor);
        q = (mag << FRAC) / dv;
        return (d < 0) ? -q : q;
    endfunction

    function automatic longint clamp_unit(longint v);
        longint one;
        one = longint'(1) << FRAC;
        if (v > one)
            return one;
        if (v < -one)
            return -one;
        return v;
    endfunction

    // Packet framing and position update for one accepted byte
    task automatic track_mouse_byte(logic [BYTE_W-1:0] status, logic [BYTE_W-1:0] data);
        mouse_report_t rep;
        if ((status & AUX_FLAG) == '0)
            return;
        case (model_pos)
            ps2mt_pkg::BYTE_HDR:
            begin
                model_header = data;
                model_pos = ps2mt_pkg::BYTE_X;
            end
            ps2mt_pkg::BYTE_X:
            begin
                model_dx = data;
                model_pos = ps2mt_pkg::BYTE_Y;
            end
            default:
            begin
                model_pos = ps2mt_pkg::BYTE_HDR;
                model_x = clamp_unit(model_x +
                    scaled_move(model_dx, model_header[ps2mt_pkg::XSIGN_BIT], model_width));
                model_y = clamp_unit(model_y -
                    scaled_move(data, model_header[ps2mt_pkg::YSIGN_BIT], model_height));
                rep.x_pos = model_x[POS_W-1:0];
                rep.y_pos = model_y[POS_W-1:0];
                rep.levels = model_header[BTN_W-1:0];
                rep.changes = model_header[BTN_W-1:0] ^ model_buttons;
                rep.pad = '0;
                model_buttons = model_header[BTN_W-1:0];
                expected_reports.push_back(rep);
            end
        endcase
    endtask

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTED)
            $display("MISMATCH: %s", msg);
    endtask

    // Driver: bursts from the pending queue with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                track_mouse_byte(s_tuser, s_tdata);
                reads_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reads.size() > 0)
                begin
                    next_read = pending_reads.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= next_read.status;
                    s_tdata <= next_read.data;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall modes, re-picked periodically, plus periodic long hold-offs
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            rx_cycle++;
            if (rx_cycle % 128 == 0)
                rx_mode = $urandom_range(0, 3);
            if (rx_cycle % 3000 == 700)
                hold_left = 300;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= rx_cycle[0];
                endcase
            end
        end
    end

    // Monitor: compare each taken report with the oldest expectation
    always @(posedge clk)
    begin
        mouse_report_t got;
        mouse_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.x_pos = m_tdata[POS_W-1:0];
            got.y_pos = m_tdata[2*POS_W-1:POS_W];
            got.levels = m_tdata[2*POS_W+BTN_W-1:2*POS_W];
            got.changes = m_tdata[2*POS_W+2*BTN_W-1:2*POS_W+BTN_W];
            got.pad = m_tdata[OUT_TDATA_W-1:2*POS_W+2*BTN_W];
            if (expected_reports.size() == 0)
            begin
                note_failure($sformatf("report with none expected, x=%0d y=%0d",
                    $signed(got.x_pos), $signed(got.y_pos)));
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.x_pos !== want.x_pos)
                    note_failure($sformatf("x_position expected %0d got %0d",
                        $signed(want.x_pos), $signed(got.x_pos)));
                if (got.y_pos !== want.y_pos)
                    note_failure($sformatf("y_position expected %0d got %0d",
                        $signed(want.y_pos), $signed(got.y_pos)));
                if (got.levels !== want.levels)
                    note_failure($sformatf("button_levels expected %b got %b",
                        want.levels, got.levels));
                if (got.changes !== want.changes)
                    note_failure($sformatf("button_changes expected %b got %b",
                        want.changes, got.changes));
                if (got.pad !== want.pad)
                    note_failure($sformatf("padding expected 0 got %h", got.pad));
            end
        end
    end

    task automatic queue_read(logic [BYTE_W-1:0] status, logic [BYTE_W-1:0] data);
        ctrl_read_t rd;
        rd.status = status;
        rd.data = data;
        pending_reads.push_back(rd);
        reads_queued++;
    endtask

    function automatic logic [BYTE_W-1:0] aux_status();
        return BYTE_W'($urandom_range(0, 255)) | AUX_FLAG;
    endfunction

    task automatic queue_packet(logic [BYTE_W-1:0] hdr, logic [BYTE_W-1:0] dx,
                                logic [BYTE_W-1:0] dy);
        queue_read(aux_status(), hdr);
        queue_read(aux_status(), dx);
        queue_read(aux_status(), dy);
    endtask

    // Delta byte: often small moves either way, otherwise anything
    function automatic logic [BYTE_W-1:0] random_delta();
        case ($urandom_range(0, 3))
            0: return BYTE_W'($urandom_range(0, 15));
            1: return BYTE_W'($urandom_range(240, 255));
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly whole packets; some stray mouse bytes and non-mouse noise
    task automatic queue_random_traffic(int count);
        int made;
        int pick;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                queue_read(BYTE_W'($urandom_range(0, 255)) & ~AUX_FLAG,
                           BYTE_W'($urandom_range(0, 255)));
            end
            else if (pick < 13)
            begin
                queue_read(aux_status(), BYTE_W'($urandom_range(0, 255)));
                made++;
            end
            else
            begin
                queue_packet(BYTE_W'($urandom_range(0, 255)), random_delta(), random_delta());
                made += 3;
            end
        end
    endtask

    // Wait until every byte is taken and every report seen, then let the divider settle
    task automatic drain_and_settle();
        while (reads_taken != reads_queued || expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_screen_reg(logic [CFG_IDX_W-1:0] idx, logic [DIVISOR_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == ps2mt_pkg::REG_SCREEN_WIDTH)
            model_width = value;
        else if (idx == ps2mt_pkg::REG_SCREEN_HEIGHT)
            model_height = value;
    endtask

    task automatic set_screen(logic [DIVISOR_W-1:0] w, logic [DIVISOR_W-1:0] h);
        write_screen_reg(ps2mt_pkg::REG_SCREEN_WIDTH, w);
        write_screen_reg(ps2mt_pkg::REG_SCREEN_HEIGHT, h);
    endtask

    // Limit on the whole run
    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        model_width = ps2mt_pkg::WIDTH_RESET;
        model_height = ps2mt_pkg::HEIGHT_RESET;
        model_pos = ps2mt_pkg::BYTE_HDR;
        model_header = '0;
        model_dx = '0;
        model_x = 0;
        model_y = 0;
        model_buttons = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: ignored bytes, sign extension extremes, saturation, no header sync
        queue_read(8'h00, 8'h00);
        queue_read(8'hDF, 8'hFF);
        queue_packet(8'h0F, 8'hFF, 8'h7F);
        queue_read(8'h20, 8'h00);
        queue_read(8'h1F, 8'h55);
        queue_read(8'hFF, 8'hFF);
        queue_read(8'h20, 8'h00);
        queue_packet(8'h30, 8'h00, 8'h00);
        queue_packet(8'hF9, 8'h80, 8'h80);
        queue_packet(8'h02, 8'hFF, 8'hFF);
        queue_packet(8'h02, 8'hFF, 8'hFF);
        queue_packet(8'h34, 8'h01, 8'hFF);
        drain_and_settle();

        // Zero divisors act as one: every nonzero delta moves a full unit or more
        set_screen('0, '0);
        queue_packet(8'h01, 8'h00, 8'hFF);
        queue_packet(8'h30, 8'h00, 8'h00);
        queue_random_traffic(66);
        drain_and_settle();

        set_screen(15'd1, 15'h7FFF);
        queue_random_traffic(75);
        drain_and_settle();

        set_screen(15'd16384, 15'd1);
        queue_random_traffic(75);
        drain_and_settle();

        // Divisors beyond the usual range are used as they are
        set_screen(15'h7FFF, 15'd16384);
        queue_random_traffic(75);
        drain_and_settle();

        set_screen(DIVISOR_W'($urandom_range(1, 32767)), DIVISOR_W'($urandom_range(1, 32767)));
        queue_random_traffic(75);
        drain_and_settle();

        set_screen(DIVISOR_W'($urandom_range(1, 64)), DIVISOR_W'($urandom_range(1, 2048)));
        queue_random_traffic(75);
        drain_and_settle();

        set_screen(ps2mt_pkg::WIDTH_RESET, ps2mt_pkg::HEIGHT_RESET);
        queue_random_traffic(75);
        drain_and_settle();

        fail_count += expected_reports.size();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
sv/ps2mt_pkg.sv
sv/ps2_mouse_packet_tracker.sv
tb/sv/tb_ps2_mouse_packet_tracker.sv
